@@ src/brtc_pkg.sv @@
// Package for the BCD clock reading check and time offset block.
// Holds register indexes, error bit positions, month tables and decode helpers.
// No dependencies.
package brtc_pkg;

   localparam logic [7:0] BAD_DIGIT = 8'hFF;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLOCK_FAULTY  = 3'd0,
      CSR_OFFSET_DAY    = 3'd1,
      CSR_OFFSET_HOUR   = 3'd2,
      CSR_OFFSET_MINUTE = 3'd3,
      CSR_OFFSET_SECOND = 3'd4
   } csr_index_type;

   localparam int unsigned ERR_BATTERY = 0;
   localparam int unsigned ERR_BACKUP  = 1;
   localparam int unsigned ERR_YEAR    = 2;
   localparam int unsigned ERR_MONTH   = 3;
   localparam int unsigned ERR_DAY     = 4;
   localparam int unsigned ERR_HOUR    = 5;
   localparam int unsigned ERR_MINUTE  = 6;
   localparam int unsigned ERR_SECOND  = 7;

   localparam logic [7:0] MONTHS_PER_YEAR = 8'd12;
   localparam logic [7:0] MAX_HOUR        = 8'd24;
   localparam logic [7:0] MAX_MIN_SEC     = 8'd60;
   localparam logic [7:0] SEC_PER_MIN     = 8'd60;
   localparam logic [7:0] HOUR_PER_DAY    = 8'd24;
   localparam logic [16:0] DAYS_PER_YEAR  = 17'd365;

   // days before the start of month index i (January is index 0)
   localparam logic [8:0] MONTH_CUM [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // decode a BCD byte, bad digits give BAD_DIGIT
   function automatic logic [7:0] bcd_decode(input logic [7:0] b);
      logic [7:0] v;
      v = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
      if (b >= 8'hA0 || b[3:0] >= 4'hA) begin
         v = BAD_DIGIT;
      end
      return v;
   endfunction

   // leap test for decoded years 0..255: 100 and 200 are the only centuries that are not leap
   function automatic logic is_leap(input logic [7:0] y);
      return (y[1:0] == 2'b00) && (y != 8'd100) && (y != 8'd200);
   endfunction

endpackage

@@ src/bcd_rtc_check_and_time_offset_unit.sv @@
// Top level of the BCD clock reading check and time offset block; depends on brtc_pkg.
// Input register, single pass of check/day count/offset logic, result register.
// Throughput: one transaction per cycle; a stalled result holds off intake only once
//    the input register also holds a transaction. CSR writes are always taken.
// Reset: synchronous, active high; clears both pipeline valids and all CSRs.
module bcd_rtc_check_and_time_offset_unit (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_power_low,
   input  logic                req_backup_valid,
   input  logic [7:0]          req_year_bcd,
   input  logic [7:0]          req_month_bcd,
   input  logic [7:0]          req_day_bcd,
   input  logic [7:0]          req_hour_bcd,
   input  logic [7:0]          req_minute_bcd,
   input  logic [7:0]          req_second_bcd,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_error_mask,
   output logic [15:0]         rsp_day_count,
   output logic signed [15:0]  rsp_game_day,
   output logic signed [7:0]   rsp_game_hour,
   output logic signed [7:0]   rsp_game_minute,
   output logic signed [7:0]   rsp_game_second,
   // CSR write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [brtc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [brtc_pkg::CSR_DATA_W-1:0]       csr_data
);

   // configuration registers
   logic        clock_faulty_ff;
   logic [15:0] offset_day_ff;
   logic [4:0]  offset_hour_ff;
   logic [5:0]  offset_minute_ff;
   logic [5:0]  offset_second_ff;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic        in_power_low_ff, in_backup_valid_ff;
   logic [7:0]  in_year_ff, in_month_ff, in_day_ff;
   logic [7:0]  in_hour_ff, in_minute_ff, in_second_ff;

   // result stage
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  error_mask_ff, error_mask_in;
   logic [15:0] day_count_ff, day_count_in;
   logic [15:0] game_day_ff, game_day_in;
   logic [7:0]  game_hour_ff, game_hour_in;
   logic [7:0]  game_minute_ff, game_minute_in;
   logic [7:0]  game_second_ff, game_second_in;

   logic out_free;
   logic in_take;

   // CSR writes are taken every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_faulty_ff  <= 1'b0;
         offset_day_ff    <= '0;
         offset_hour_ff   <= '0;
         offset_minute_ff <= '0;
         offset_second_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (brtc_pkg::csr_index_type'(csr_index))
            brtc_pkg::CSR_CLOCK_FAULTY:  clock_faulty_ff  <= csr_data[0];
            brtc_pkg::CSR_OFFSET_DAY:    offset_day_ff    <= csr_data[15:0];
            brtc_pkg::CSR_OFFSET_HOUR:   offset_hour_ff   <= csr_data[4:0];
            brtc_pkg::CSR_OFFSET_MINUTE: offset_minute_ff <= csr_data[5:0];
            brtc_pkg::CSR_OFFSET_SECOND: offset_second_ff <= csr_data[5:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // Advance the result register whenever it is empty or being drained; the input
   // register passes its request on as it advances, and takes a new one whenever empty or passing on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (out_free) begin
         in_valid_in = 1'b0;
      end
      if (in_take) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request payload until the result stage takes it
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_power_low_ff    <= req_power_low;
         in_backup_valid_ff <= req_backup_valid;
         in_year_ff         <= req_year_bcd;
         in_month_ff        <= req_month_bcd;
         in_day_ff          <= req_day_bcd;
         in_hour_ff         <= req_hour_bcd;
         in_minute_ff       <= req_minute_bcd;
         in_second_ff       <= req_second_bcd;
      end
   end

   // ---------------------------------------------------------------------
   // Check and day count logic
   // ---------------------------------------------------------------------
   logic [7:0]  dec_year, dec_month, dec_day, dec_hour, dec_minute, dec_second;
   logic        month_bad;
   logic [3:0]  len_index;
   logic [5:0]  day_limit;
   logic        day_bad;

   logic [7:0]  eff_year, eff_month, eff_day, eff_hour, eff_minute, eff_second;
   logic [7:0]  prev_years;
   logic [16:0] prev_years_w;
   logic [1:0]  centuries;
   logic [16:0] year_days;
   logic [3:0]  cum_index;
   logic        leap_bonus;
   logic [16:0] total_days;

   logic [7:0]  sec_raw, min_raw, hour_raw;
   logic [7:0]  min_adj, hour_adj;
   logic [15:0] day_raw;
   logic        sec_borrow, min_borrow, hour_borrow;

   always_comb begin
      dec_year   = brtc_pkg::bcd_decode(in_year_ff);
      dec_month  = brtc_pkg::bcd_decode(in_month_ff);
      dec_day    = brtc_pkg::bcd_decode(in_day_ff);
      dec_hour   = brtc_pkg::bcd_decode(in_hour_ff);
      dec_minute = brtc_pkg::bcd_decode(in_minute_ff);
      dec_second = brtc_pkg::bcd_decode(in_second_ff);

      // a bad month covers the 255 code too; skip the length check then
      month_bad = (dec_month == 8'd0) || (dec_month > brtc_pkg::MONTHS_PER_YEAR);
      len_index = month_bad ? 4'd0 : 4'(dec_month - 8'd1);
      day_limit = {1'b0, brtc_pkg::MONTH_LEN[len_index]}
                + {5'd0, (dec_month == 8'd2) && brtc_pkg::is_leap(dec_year)};
      day_bad   = (dec_day == brtc_pkg::BAD_DIGIT)
               || (!month_bad && (dec_day > {2'b00, day_limit}));

      error_mask_in = '0;
      error_mask_in[brtc_pkg::ERR_BATTERY] = in_power_low_ff;
      error_mask_in[brtc_pkg::ERR_BACKUP]  = !in_backup_valid_ff;
      error_mask_in[brtc_pkg::ERR_YEAR]    = (dec_year == brtc_pkg::BAD_DIGIT);
      error_mask_in[brtc_pkg::ERR_MONTH]   = month_bad;
      error_mask_in[brtc_pkg::ERR_DAY]     = day_bad;
      error_mask_in[brtc_pkg::ERR_HOUR]    = (dec_hour > brtc_pkg::MAX_HOUR);
      error_mask_in[brtc_pkg::ERR_MINUTE]  = (dec_minute > brtc_pkg::MAX_MIN_SEC);
      error_mask_in[brtc_pkg::ERR_SECOND]  = (dec_second > brtc_pkg::MAX_MIN_SEC);

      // a faulty clock counts from the default time 00/01/01 00:00:00
      if (clock_faulty_ff) begin
         eff_year   = 8'd0;
         eff_month  = 8'd1;
         eff_day    = 8'd1;
         eff_hour   = 8'd0;
         eff_minute = 8'd0;
         eff_second = 8'd0;
      end else begin
         eff_year   = dec_year;
         eff_month  = dec_month;
         eff_day    = dec_day;
         eff_hour   = dec_hour;
         eff_minute = dec_minute;
         eff_second = dec_second;
      end

      // whole years before this one; fewer than 400 so no 400-year term
      prev_years   = eff_year - 8'd1;
      prev_years_w = {9'd0, prev_years};
      if (prev_years >= 8'd200) begin
         centuries = 2'd2;
      end else if (prev_years >= 8'd100) begin
         centuries = 2'd1;
      end else begin
         centuries = 2'd0;
      end
      if (eff_year == 8'd0) begin
         year_days = '0;
      end else begin
         year_days = prev_years_w * brtc_pkg::DAYS_PER_YEAR
                   + (prev_years_w >> 2) - {15'd0, centuries};
      end

      // months past December count as the whole year
      if (eff_month == 8'd0) begin
         cum_index = 4'd0;
      end else if (eff_month > brtc_pkg::MONTHS_PER_YEAR) begin
         cum_index = 4'd12;
      end else begin
         cum_index = 4'(eff_month - 8'd1);
      end
      leap_bonus = (eff_month > 8'd2) && brtc_pkg::is_leap(eff_year);
      total_days = year_days + {8'd0, brtc_pkg::MONTH_CUM[cum_index]}
                 + {16'd0, leap_bonus} + {9'd0, eff_day};
      day_count_in = total_days[15:0];

      // offset with borrow rippling from seconds up to days, all wrapping
      sec_raw  = eff_second - {2'b00, offset_second_ff};
      min_raw  = eff_minute - {2'b00, offset_minute_ff};
      hour_raw = eff_hour - {3'b000, offset_hour_ff};
      day_raw  = day_count_in - offset_day_ff;

      sec_borrow     = sec_raw[7];
      game_second_in = sec_borrow ? sec_raw + brtc_pkg::SEC_PER_MIN : sec_raw;
      min_adj        = sec_borrow ? min_raw - 8'd1 : min_raw;

      min_borrow     = min_adj[7];
      game_minute_in = min_borrow ? min_adj + brtc_pkg::SEC_PER_MIN : min_adj;
      hour_adj       = min_borrow ? hour_raw - 8'd1 : hour_raw;

      hour_borrow    = hour_adj[7];
      game_hour_in   = hour_borrow ? hour_adj + brtc_pkg::HOUR_PER_DAY : hour_adj;
      game_day_in    = hour_borrow ? day_raw - 16'd1 : day_raw;
   end

   // load results only when the stage advances; hold them under stall
   always_ff @(posedge clock) begin
      if (out_free) begin
         error_mask_ff  <= error_mask_in;
         day_count_ff   <= day_count_in;
         game_day_ff    <= game_day_in;
         game_hour_ff   <= game_hour_in;
         game_minute_ff <= game_minute_in;
         game_second_ff <= game_second_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_mask  = error_mask_ff;
   assign rsp_day_count   = day_count_ff;
   assign rsp_game_day    = $signed(game_day_ff);
   assign rsp_game_hour   = $signed(game_hour_ff);
   assign rsp_game_minute = $signed(game_minute_ff);
   assign rsp_game_second = $signed(game_second_ff);

`ifndef SYNTH
   // a pending request always moves into a free result stage
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free) |=> rsp_valid_ff)
      else $error("pending request not moved to result stage");

   // intake only stalls when a request is actually held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with nothing held");

   // a stalled result stage keeps the held request in place
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_year_ff)))
      else $error("held request lost under stall");

   // a drained result with no pending request leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !in_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated after drain");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for bcd_rtc_check_and_time_offset_unit.
// Readings in, error masks and game time out; predicts each result from its own CSR copy.
// Depends on brtc_pkg and the block.

typedef struct packed {
   logic       power_low;
   logic       backup_valid;
   logic [7:0] year;
   logic [7:0] month;
   logic [7:0] day;
   logic [7:0] hour;
   logic [7:0] minute;
   logic [7:0] second;
} rtc_reading_type;

typedef struct packed {
   logic [7:0]  error_mask;
   logic [15:0] day_count;
   logic [15:0] game_day;
   logic [7:0]  game_hour;
   logic [7:0]  game_minute;
   logic [7:0]  game_second;
} rtc_result_type;

// Holds the CSR copy and the results still owed by the block, oldest first.
class rtc_reading_ledger;
   rtc_result_type expected_results[$];
   int unsigned mismatches;
   logic        clock_faulty;
   logic [15:0] offset_day;
   logic [7:0]  offset_hour;
   logic [7:0]  offset_minute;
   logic [7:0]  offset_second;

   function new();
      mismatches    = 0;
      clock_faulty  = 1'b0;
      offset_day    = '0;
      offset_hour   = '0;
      offset_minute = '0;
      offset_second = '0;
   endfunction

   function void apply_register(brtc_pkg::csr_index_type idx, logic [15:0] value);
      case (idx)
         brtc_pkg::CSR_CLOCK_FAULTY:  clock_faulty  = value[0];
         brtc_pkg::CSR_OFFSET_DAY:    offset_day    = value;
         brtc_pkg::CSR_OFFSET_HOUR:   offset_hour   = {3'b000, value[4:0]};
         brtc_pkg::CSR_OFFSET_MINUTE: offset_minute = {2'b00, value[5:0]};
         brtc_pkg::CSR_OFFSET_SECOND: offset_second = {2'b00, value[5:0]};
         default: ;
      endcase
   endfunction

   function int decode_bcd(logic [7:0] b);
      if (b[7:4] > 4'd9 || b[3:0] > 4'd9) return int'(brtc_pkg::BAD_DIGIT);
      return b[7:4] * 10 + b[3:0];
   endfunction

   function bit year_has_feb29(int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   function int month_limit(int mo, int yr);
      case (mo)
         2:           return year_has_feb29(yr) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function rtc_result_type evaluate_reading(rtc_reading_type r);
      rtc_result_type res;
      int          yr, mo, dy, hr, mn, sc, span, days, i;
      logic        month_bad;
      yr = decode_bcd(r.year);
      mo = decode_bcd(r.month);
      dy = decode_bcd(r.day);
      hr = decode_bcd(r.hour);
      mn = decode_bcd(r.minute);
      sc = decode_bcd(r.second);

      month_bad = (mo == int'(brtc_pkg::BAD_DIGIT)) || (mo == 0) || (mo > 12);
      res.error_mask                        = '0;
      res.error_mask[brtc_pkg::ERR_BATTERY] = r.power_low;
      res.error_mask[brtc_pkg::ERR_BACKUP]  = !r.backup_valid;
      res.error_mask[brtc_pkg::ERR_YEAR]    = (yr == int'(brtc_pkg::BAD_DIGIT));
      res.error_mask[brtc_pkg::ERR_MONTH]   = month_bad;
      // month length only counts once the month itself is good
      res.error_mask[brtc_pkg::ERR_DAY]     = (dy == int'(brtc_pkg::BAD_DIGIT)) ||
                                              (!month_bad && dy > month_limit(mo, yr));
      res.error_mask[brtc_pkg::ERR_HOUR]    = (hr > 24);
      res.error_mask[brtc_pkg::ERR_MINUTE]  = (mn > 60);
      res.error_mask[brtc_pkg::ERR_SECOND]  = (sc > 60);

      if (clock_faulty) begin
         yr = 0; mo = 1; dy = 1; hr = 0; mn = 0; sc = 0;
      end
      days = 0;
      if (yr > 0) begin
         days = 365 * (yr - 1) + (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400;
      end
      // months beyond twelve count the whole year; leap February folds in here
      span = (mo == 0) ? 0 : ((mo > 12) ? 12 : mo - 1);
      for (i = 1; i <= span; i++) begin
         days += month_limit(i, yr);
      end
      days += dy;

      res.day_count   = 16'(days);
      res.game_day    = 16'(days) - offset_day;
      res.game_hour   = 8'(hr) - offset_hour;
      res.game_minute = 8'(mn) - offset_minute;
      res.game_second = 8'(sc) - offset_second;
      if (res.game_second[7]) begin
         res.game_second = res.game_second + 8'd60;
         res.game_minute = res.game_minute - 8'd1;
      end
      if (res.game_minute[7]) begin
         res.game_minute = res.game_minute + 8'd60;
         res.game_hour   = res.game_hour - 8'd1;
      end
      if (res.game_hour[7]) begin
         res.game_hour = res.game_hour + 8'd24;
         res.game_day  = res.game_day - 16'd1;
      end
      return res;
   endfunction

   function void note_reading(rtc_reading_type r);
      expected_results.push_back(evaluate_reading(r));
   endfunction

   function int unsigned pending();
      return expected_results.size();
   endfunction

   function void check_result(rtc_result_type got);
      rtc_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected result transaction: mask=%h day_count=%0d",
                     got.error_mask, got.day_count);
         end
         return;
      end
      want = expected_results.pop_front();
      if (got.error_mask !== want.error_mask || got.day_count !== want.day_count ||
          got.game_day !== want.game_day || got.game_hour !== want.game_hour ||
          got.game_minute !== want.game_minute || got.game_second !== want.game_second)
      begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: want mask=%h days=%0d game=%0d %0d:%0d:%0d",
                     want.error_mask, want.day_count, $signed(want.game_day),
                     $signed(want.game_hour), $signed(want.game_minute),
                     $signed(want.game_second));
            $display("          got  mask=%h days=%0d game=%0d %0d:%0d:%0d",
                     got.error_mask, got.day_count, $signed(got.game_day),
                     $signed(got.game_hour), $signed(got.game_minute),
                     $signed(got.game_second));
         end
      end
   endfunction
endclass

module tb;

   localparam int unsigned LIMIT_CYCLES    = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 60;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned PHASE_ITEMS     = 116;

   logic               clock = 1'b0;
   logic               reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_power_low    = 1'b0;
   logic               req_backup_valid = 1'b0;
   logic [7:0]         req_year_bcd     = '0;
   logic [7:0]         req_month_bcd    = '0;
   logic [7:0]         req_day_bcd      = '0;
   logic [7:0]         req_hour_bcd     = '0;
   logic [7:0]         req_minute_bcd   = '0;
   logic [7:0]         req_second_bcd   = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_error_mask;
   logic [15:0]        rsp_day_count;
   logic signed [15:0] rsp_game_day;
   logic signed [7:0]  rsp_game_hour;
   logic signed [7:0]  rsp_game_minute;
   logic signed [7:0]  rsp_game_second;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   brtc_pkg::csr_index_type         csr_index = brtc_pkg::CSR_CLOCK_FAULTY;
   logic [brtc_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // per-item idle draws: sender gap and receiver stall, 0 up to these bounds
   int unsigned        sender_gap_max  = 4;
   int unsigned        receiver_gap_max = 4;
   bit                 hold_off_pending = 1'b0;
   int unsigned        cycle_count      = 0;

   rtc_reading_ledger  ledger = new();

   bcd_rtc_check_and_time_offset_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_power_low    (req_power_low),
      .req_backup_valid (req_backup_valid),
      .req_year_bcd     (req_year_bcd),
      .req_month_bcd    (req_month_bcd),
      .req_day_bcd      (req_day_bcd),
      .req_hour_bcd     (req_hour_bcd),
      .req_minute_bcd   (req_minute_bcd),
      .req_second_bcd   (req_second_bcd),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_error_mask   (rsp_error_mask),
      .rsp_day_count    (rsp_day_count),
      .rsp_game_day     (rsp_game_day),
      .rsp_game_hour    (rsp_game_hour),
      .rsp_game_minute  (rsp_game_minute),
      .rsp_game_second  (rsp_game_second),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // Hard stop: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Sample results on the edge that accepts them; stall here is the value
   // held since the previous edge, so no ordering within the step matters.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         ledger.check_result('{rsp_error_mask, rsp_day_count, rsp_game_day,
                               rsp_game_hour, rsp_game_minute, rsp_game_second});
      end
   end

   // Result side: draw a stall per result, or hold off for a long stretch
   // when asked, so that the pipeline fills and pushes back on intake.
   initial begin : receiver
      int unsigned wait_cycles;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_pending) begin
            wait_cycles      = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end else begin
            wait_cycles = $urandom_range(0, receiver_gap_max);
         end
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   function automatic logic [7:0] to_bcd(int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Mostly well-formed readings near the limits, then plain decimal noise,
   // then raw bytes that hit the bad-digit decode.
   function automatic rtc_reading_type random_reading();
      rtc_reading_type r;
      int unsigned  kind, yr, mo;
      kind           = $urandom_range(0, 9);
      r.power_low    = ($urandom_range(0, 3) == 0);
      r.backup_valid = ($urandom_range(0, 3) != 0);
      if (kind < 7) begin
         yr       = $urandom_range(0, 99);
         mo       = $urandom_range(1, 12);
         r.year   = to_bcd(yr);
         r.month  = to_bcd(mo);
         r.day    = to_bcd($urandom_range(0, ledger.month_limit(mo, yr) + 1));
         r.hour   = to_bcd($urandom_range(0, 25));
         r.minute = to_bcd($urandom_range(0, 61));
         r.second = to_bcd($urandom_range(0, 61));
         // spoil one field of an otherwise good reading now and then
         if (kind == 6) begin
            case ($urandom_range(0, 5))
               0:       r.year   = 8'($urandom);
               1:       r.month  = 8'($urandom);
               2:       r.day    = 8'($urandom);
               3:       r.hour   = 8'($urandom);
               4:       r.minute = 8'($urandom);
               default: r.second = 8'($urandom);
            endcase
         end
      end else if (kind < 9) begin
         r.year   = to_bcd($urandom_range(0, 99));
         r.month  = to_bcd($urandom_range(0, 99));
         r.day    = to_bcd($urandom_range(0, 99));
         r.hour   = to_bcd($urandom_range(0, 99));
         r.minute = to_bcd($urandom_range(0, 99));
         r.second = to_bcd($urandom_range(0, 99));
      end else begin
         r.year   = 8'($urandom);
         r.month  = 8'($urandom);
         r.day    = 8'($urandom);
         r.hour   = 8'($urandom);
         r.minute = 8'($urandom);
         r.second = 8'($urandom);
      end
      return r;
   endfunction

   // Offer one reading after a random gap; hold the payload until accepted.
   // Valid stays high across back-to-back transactions.
   task automatic send_reading(rtc_reading_type r);
      int unsigned gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_power_low    <= r.power_low;
      req_backup_valid <= r.backup_valid;
      req_year_bcd     <= r.year;
      req_month_bcd    <= r.month;
      req_day_bcd      <= r.day;
      req_hour_bcd     <= r.hour;
      req_minute_bcd   <= r.minute;
      req_second_bcd   <= r.second;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.note_reading(r);
   endtask

   // Drop valid and wait for every owed result to come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Write all five CSRs back to back; only call with the block idle.
   task automatic program_registers(logic faulty, logic [15:0] day_off,
                                    logic [4:0] hour_off, logic [5:0] min_off,
                                    logic [5:0] sec_off);
      brtc_pkg::csr_index_type order [5];
      logic [15:0]             value [5];
      int                      i;
      order = '{brtc_pkg::CSR_CLOCK_FAULTY, brtc_pkg::CSR_OFFSET_DAY,
                brtc_pkg::CSR_OFFSET_HOUR, brtc_pkg::CSR_OFFSET_MINUTE,
                brtc_pkg::CSR_OFFSET_SECOND};
      value = '{{15'd0, faulty}, day_off, {11'd0, hour_off},
                {10'd0, min_off}, {10'd0, sec_off}};
      csr_valid <= 1'b1;
      for (i = 0; i < 5; i++) begin
         csr_index <= order[i];
         csr_data  <= value[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
         ledger.apply_register(order[i], value[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned phase, n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed readings at reset configuration: leap days, boundaries,
      // bad digits in either nibble, month zero and beyond twelve.
      send_reading('{1'b0, 1'b1, 8'h24, 8'h02, 8'h29, 8'h12, 8'h34, 8'h56});
      send_reading('{1'b0, 1'b1, 8'h23, 8'h02, 8'h29, 8'h12, 8'h34, 8'h56});
      send_reading('{1'b0, 1'b1, 8'h00, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b0, 1'b1, 8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
      send_reading('{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_reading('{1'b1, 1'b1, 8'h1A, 8'h0A, 8'h1B, 8'h2C, 8'h3D, 8'h4E});
      send_reading('{1'b0, 1'b1, 8'hA0, 8'hB1, 8'hC2, 8'hD3, 8'hE4, 8'hF5});
      send_reading('{1'b0, 1'b1, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99, 8'h99});
      send_reading('{1'b0, 1'b1, 8'h50, 8'h01, 8'h31, 8'h24, 8'h60, 8'h60});
      send_reading('{1'b0, 1'b1, 8'h50, 8'h01, 8'h31, 8'h25, 8'h61, 8'h61});
      send_reading('{1'b0, 1'b1, 8'h50, 8'h13, 8'h31, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b0, 1'b1, 8'h50, 8'h12, 8'h32, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b0, 1'b1, 8'h50, 8'h04, 8'h31, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b0, 1'b1, 8'h50, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b0, 1'b1, 8'h96, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00});

      // Largest offsets: midnight on day one borrows all the way into the day.
      drain();
      program_registers(1'b0, 16'h7FFF, 5'd23, 6'd59, 6'd59);
      send_reading('{1'b0, 1'b1, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading('{1'b0, 1'b1, 8'h99, 8'h12, 8'h31, 8'h24, 8'h60, 8'h60});

      // Faulty clock: default time for the counts, the mask still checks the reading.
      drain();
      program_registers(1'b1, 16'h8000, 5'd0, 6'd0, 6'd0);
      send_reading('{1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_reading('{1'b0, 1'b1, 8'h24, 8'h06, 8'h15, 8'h10, 8'h20, 8'h30});

      // Random phases, each under its own CSR setting, extremes first.
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: program_registers(1'b0, 16'h0000, 5'd0, 6'd0, 6'd0);
            1: program_registers(1'b0, 16'h7FFF, 5'd23, 6'd59, 6'd59);
            2: program_registers(1'b0, 16'h8000, 5'd0, 6'd59, 6'd0);
            3: program_registers(1'b1, 16'($urandom), 5'($urandom_range(0, 23)),
                                 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
            default: program_registers(1'($urandom), 16'($urandom),
                                       5'($urandom_range(0, 23)),
                                       6'($urandom_range(0, 59)),
                                       6'($urandom_range(0, 59)));
         endcase
         // phase 3 runs flat out on both sides, phase 5 never stalls results
         sender_gap_max   = (phase == 3) ? 0 : 4;
         receiver_gap_max = (phase == 3 || phase == 5) ? 0 : 4;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 40) hold_off_pending = 1'b1;
            if (phase == 4 && n == 60) drain();
            send_reading(random_reading());
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ bcd_rtc_check_and_time_offset_unit.f @@
src/brtc_pkg.sv
src/bcd_rtc_check_and_time_offset_unit.sv
verif/tb.sv
